>>> rtl/core/pcnt_pkg.sv
`default_nettype none

package pcnt_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned PIN_W  = 6;
  localparam int unsigned LVL_W  = 64;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_REG   = 2'd0,
    OP_DEREG = 2'd1,
    OP_SCAN  = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_QUIET  = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_NOCHG = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic mem_we;
    logic set_valid;
    logic clr_valid;
  } tbl_ctl_t;

  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic [PIN_W-1:0] event_pin;
    logic             new_level;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/pcnt_ifs.sv
`default_nettype none

interface pcnt_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcnt_pkg::OP_W-1:0]   op;
  logic [pcnt_pkg::PIN_W-1:0]  pin_id;
  logic [pcnt_pkg::LVL_W-1:0]  pin_levels;

  modport source (output valid, op, pin_id, pin_levels, input ready);
  modport sink (input valid, op, pin_id, pin_levels, output ready);
endinterface

interface pcnt_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcnt_pkg::KIND_W-1:0] kind;
  logic [pcnt_pkg::STAT_W-1:0] status;
  logic [pcnt_pkg::PIN_W-1:0]  event_pin;
  logic                        new_level;
  logic                        last;

  modport source (output valid, kind, status, event_pin, new_level, last, input ready);
  modport sink (input valid, kind, status, event_pin, new_level, last, output ready);
endinterface

interface pcnt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pcnt_pkg::LVL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pin_change_notifier_table_core.sv
// Register, deregister and scan walk the table one entry per cycle through the
// single read port of the entry memory; a scan holds its walk while a held change waits
// on a stalled output. An undefined op skips the walk and answers with a miss status.
// A new item is taken only after the previous one's final result has entered the output register.
// Reset clears all valid marks and sets the changeable mask to all ones; no clearing pass.
`default_nettype none

module pin_change_notifier_table_core #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PIN_COUNT = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pcnt_in_if.sink     in_i,
  pcnt_out_if.source  out_o,
  pcnt_cfg_if.sink    cfg_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [PIN_COUNT-1:0]          changeable_q;
  pcnt_pkg::tbl_ctl_t            ctl;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              wr_addr;
  logic [pcnt_pkg::PIN_W-1:0]    wr_pin;
  logic                          wr_level;
  logic [pcnt_pkg::PIN_W-1:0]    rd_pin;
  logic                          rd_level;
  logic [ENTRIES-1:0]            valid;
  pcnt_pkg::res_t                res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changeable_q <= '1;
    end else if (cfg_i.valid) begin
      changeable_q <= cfg_i.data[PIN_COUNT-1:0];
    end
  end

  pcnt_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_pin_o   (rd_pin),
    .rd_level_o (rd_level),
    .ctl_i      (ctl),
    .wr_addr_i  (wr_addr),
    .wr_pin_i   (wr_pin),
    .wr_level_i (wr_level),
    .valid_o    (valid)
  );

  pcnt_seq #(
    .ENTRIES   (ENTRIES),
    .PIN_COUNT (PIN_COUNT),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_op_i      (in_i.op),
    .in_pin_i     (in_i.pin_id),
    .in_levels_i  (in_i.pin_levels),
    .changeable_i (pcnt_pkg::LVL_W'(changeable_q)),
    .ctl_o        (ctl),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .wr_pin_o     (wr_pin),
    .wr_level_o   (wr_level),
    .rd_pin_i     (rd_pin),
    .rd_level_i   (rd_level),
    .valid_i      (valid),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  assign out_o.kind      = res.kind;
  assign out_o.status    = res.status;
  assign out_o.event_pin = res.event_pin;
  assign out_o.new_level = res.new_level;
  assign out_o.last      = res.last;

endmodule

`default_nettype wire

>>> rtl/core/pcnt_table.sv
`default_nettype none

module pcnt_table #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [IDX_W-1:0]           rd_addr_i,
  output logic [pcnt_pkg::PIN_W-1:0]      rd_pin_o,
  output logic                            rd_level_o,
  input  wire pcnt_pkg::tbl_ctl_t         ctl_i,
  input  wire logic [IDX_W-1:0]           wr_addr_i,
  input  wire logic [pcnt_pkg::PIN_W-1:0] wr_pin_i,
  input  wire logic                       wr_level_i,
  output logic [ENTRIES-1:0]              valid_o
);

  // Each word holds the pin number above its last seen level.
  logic [pcnt_pkg::PIN_W:0] mem_q [ENTRIES];
  logic [pcnt_pkg::PIN_W:0] rd_q;
  logic [ENTRIES-1:0]       valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      mem_q[wr_addr_i] <= {wr_pin_i, wr_level_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.set_valid) begin
      valid_q[wr_addr_i] <= 1'b1;
    end else if (ctl_i.clr_valid) begin
      valid_q[wr_addr_i] <= 1'b0;
    end
  end

  assign rd_pin_o   = rd_q[pcnt_pkg::PIN_W:1];
  assign rd_level_o = rd_q[0];
  assign valid_o    = valid_q;

endmodule

`default_nettype wire

>>> rtl/core/pcnt_seq.sv
`default_nettype none

module pcnt_seq #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PIN_COUNT = 64,
  parameter int unsigned IDX_W     = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [pcnt_pkg::OP_W-1:0]  in_op_i,
  input  wire logic [pcnt_pkg::PIN_W-1:0] in_pin_i,
  input  wire logic [pcnt_pkg::LVL_W-1:0] in_levels_i,
  input  wire logic [pcnt_pkg::LVL_W-1:0] changeable_i,
  output pcnt_pkg::tbl_ctl_t              ctl_o,
  output logic [IDX_W-1:0]                rd_addr_o,
  output logic [IDX_W-1:0]                wr_addr_o,
  output logic [pcnt_pkg::PIN_W-1:0]      wr_pin_o,
  output logic                            wr_level_o,
  input  wire logic [pcnt_pkg::PIN_W-1:0] rd_pin_i,
  input  wire logic                       rd_level_i,
  input  wire logic [ENTRIES-1:0]         valid_i,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output pcnt_pkg::res_t                  res_o
);

  // Pins at or above PIN_COUNT read as level zero.
  localparam logic [pcnt_pkg::LVL_W-1:0] PIN_MASK =
    {pcnt_pkg::LVL_W{1'b1}} >> (pcnt_pkg::LVL_W - PIN_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  pcnt_pkg::state_e             state_q, state_d;
  logic [pcnt_pkg::OP_W-1:0]    op_q, op_d;
  logic [pcnt_pkg::PIN_W-1:0]   pin_q, pin_d;
  logic [pcnt_pkg::LVL_W-1:0]   levels_q, levels_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic                         hit_q, hit_d;
  logic                         free_q, free_d;
  logic [IDX_W-1:0]             free_idx_q, free_idx_d;
  logic                         pend_v_q, pend_v_d;
  logic [pcnt_pkg::PIN_W-1:0]   pend_pin_q, pend_pin_d;
  logic                         pend_lvl_q, pend_lvl_d;
  logic                         out_v_q, out_v_d;
  pcnt_pkg::res_t               out_q, out_d;

  logic             cur_valid;
  logic             now_lvl;
  logic             is_last;
  logic             out_free;
  logic             pin_chg;
  logic             pin_match;
  logic             adv;
  logic [IDX_W-1:0] nxt_idx;

  assign cur_valid = valid_i[idx_q];
  assign now_lvl   = levels_q[rd_pin_i];
  assign is_last   = (idx_q == LAST_IDX);
  assign out_free  = !out_v_q || res_ready_i;
  assign pin_chg   = changeable_i[pin_q];
  assign pin_match = cur_valid && (rd_pin_i == pin_q);
  assign nxt_idx   = is_last ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcnt_pkg::S_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pin_q      <= pin_d;
    levels_q   <= levels_d;
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    pend_pin_q <= pend_pin_d;
    pend_lvl_q <= pend_lvl_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pin_d      = pin_q;
    levels_d   = levels_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    pend_v_d   = pend_v_q;
    pend_pin_d = pend_pin_q;
    pend_lvl_d = pend_lvl_q;
    out_v_d    = out_v_q && !res_ready_i;
    out_d      = out_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    rd_addr_o  = idx_q;
    wr_addr_o  = idx_q;
    wr_pin_o   = rd_pin_i;
    wr_level_o = now_lvl;
    adv        = 1'b1;

    case (state_q)
      pcnt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = '0;
        if (in_valid_i) begin
          op_d     = in_op_i;
          pin_d    = in_pin_i;
          levels_d = in_levels_i & PIN_MASK;
          idx_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          pend_v_d = 1'b0;
          case (pcnt_pkg::op_e'(in_op_i))
            pcnt_pkg::OP_REG, pcnt_pkg::OP_DEREG, pcnt_pkg::OP_SCAN: begin
              state_d = pcnt_pkg::S_WALK;
            end
            default: begin
              state_d = pcnt_pkg::S_DONE;
            end
          endcase
        end
      end

      pcnt_pkg::S_WALK: begin
        case (pcnt_pkg::op_e'(op_q))
          pcnt_pkg::OP_REG: begin
            if (pin_match) begin
              hit_d = 1'b1;
            end
            if (!cur_valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = idx_q;
            end
          end
          pcnt_pkg::OP_DEREG: begin
            if (pin_match && !hit_q) begin
              hit_d           = 1'b1;
              ctl_o.clr_valid = 1'b1;
            end
          end
          pcnt_pkg::OP_SCAN: begin
            if (cur_valid && (now_lvl != rd_level_i)) begin
              // Hold one change back so the final one can carry the last flag.
              if (pend_v_q && !out_free) begin
                adv = 1'b0;
              end else begin
                if (pend_v_q) begin
                  out_v_d = 1'b1;
                  out_d   = '{kind: pcnt_pkg::KIND_CHANGE, status: pcnt_pkg::STAT_OK,
                              event_pin: pend_pin_q, new_level: pend_lvl_q, last: 1'b0};
                end
                pend_v_d     = 1'b1;
                pend_pin_d   = rd_pin_i;
                pend_lvl_d   = now_lvl;
                ctl_o.mem_we = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (adv) begin
          idx_d     = nxt_idx;
          rd_addr_o = nxt_idx;
          if (is_last) begin
            state_d = pcnt_pkg::S_DONE;
          end
        end
      end

      pcnt_pkg::S_DONE: begin
        rd_addr_o = '0;
        if (out_free) begin
          out_v_d = 1'b1;
          state_d = pcnt_pkg::S_IDLE;
          out_d   = '{kind: pcnt_pkg::KIND_STATUS, status: pcnt_pkg::STAT_MISS,
                      event_pin: '0, new_level: 1'b0, last: 1'b1};
          case (pcnt_pkg::op_e'(op_q))
            pcnt_pkg::OP_REG: begin
              if (hit_q) begin
                out_d.status = pcnt_pkg::STAT_MISS;
              end else if (free_q) begin
                ctl_o.mem_we    = 1'b1;
                ctl_o.set_valid = 1'b1;
                wr_addr_o       = free_idx_q;
                wr_pin_o        = pin_q;
                wr_level_o      = levels_q[pin_q];
                out_d.status    = pin_chg ? pcnt_pkg::STAT_OK : pcnt_pkg::STAT_NOCHG;
              end else begin
                out_d.status = pcnt_pkg::STAT_FULL;
              end
            end
            pcnt_pkg::OP_DEREG: begin
              if (hit_q) begin
                out_d.status = pin_chg ? pcnt_pkg::STAT_OK : pcnt_pkg::STAT_NOCHG;
              end
            end
            pcnt_pkg::OP_SCAN: begin
              pend_v_d     = 1'b0;
              out_d.status = pcnt_pkg::STAT_OK;
              if (pend_v_q) begin
                out_d.kind      = pcnt_pkg::KIND_CHANGE;
                out_d.event_pin = pend_pin_q;
                out_d.new_level = pend_lvl_q;
              end else begin
                out_d.kind = pcnt_pkg::KIND_QUIET;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_d = pcnt_pkg::S_IDLE;
      end
    endcase
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  a_pend_only_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (op_q == pcnt_pkg::OP_SCAN))
    else $error("held change outside a scan");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_v_q)
    else $error("held change left over when idle");

  a_quiet_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.kind == pcnt_pkg::KIND_QUIET)) |-> out_q.last)
    else $error("no-change result without last flag");

  a_dereg_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.clr_valid |=> hit_q)
    else $error("entry cleared without recording the match");

endmodule

`default_nettype wire

>>> tb/tb_pin_change_notifier_table_core.sv
`timescale 1ns / 1ps

module tb_pin_change_notifier_table_core;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned PIN_COUNT = 64;
  localparam logic [pcnt_pkg::OP_W-1:0] OP_UNDEF = 2'd3;
  localparam logic [pcnt_pkg::LVL_W-1:0] ALL_ONES = '1;
  localparam logic [pcnt_pkg::LVL_W-1:0] ALL_ZEROS = '0;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
  localparam int unsigned ITEMS_PER_PHASE = 17;

  typedef struct packed {
    logic [pcnt_pkg::OP_W-1:0]  op;
    logic [pcnt_pkg::PIN_W-1:0] pin_id;
    logic [pcnt_pkg::LVL_W-1:0] pin_levels;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcnt_in_if  in_if ();
  pcnt_out_if out_if ();
  pcnt_cfg_if cfg_if ();

  pin_change_notifier_table_core #(
    .ENTRIES  (ENTRIES),
    .PIN_COUNT(PIN_COUNT)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the pin table and of the changeable mask.
  logic [pcnt_pkg::LVL_W-1:0] mask_copy = ALL_ONES;
  bit                         ent_valid [ENTRIES];
  logic [pcnt_pkg::PIN_W-1:0] ent_pin   [ENTRIES];
  logic                       ent_level [ENTRIES];

  req_t                       req_q[$];
  pcnt_pkg::res_t             notice_q[$];
  int unsigned                mismatches = 0;
  logic                       in_fire;
  int unsigned                send_gap = 0;
  bit                         send_calm = 1'b0;
  int unsigned                take_stall = 0;
  bit                         take_calm = 1'b0;
  logic [pcnt_pkg::LVL_W-1:0] line_state;

  function automatic logic level_of(logic [pcnt_pkg::LVL_W-1:0] vec,
                                    logic [pcnt_pkg::PIN_W-1:0] pin);
    return (pin < PIN_COUNT) ? vec[pin] : 1'b0;
  endfunction

  function automatic void push_notice(pcnt_pkg::kind_e kind, pcnt_pkg::status_e status,
                                      logic [pcnt_pkg::PIN_W-1:0] pin,
                                      logic lvl, logic last);
    pcnt_pkg::res_t r;
    r.kind      = kind;
    r.status    = status;
    r.event_pin = pin;
    r.new_level = lvl;
    r.last      = last;
    notice_q.push_back(r);
  endfunction

  function automatic void apply_table_op(req_t r);
    int                int_hit_unused;
    int                hit;
    int                free_idx;
    int                n;
    logic              now;
    pcnt_pkg::status_e st;
    int_hit_unused = 0;
    hit = -1;
    free_idx = -1;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent_valid[i] && ent_pin[i] == r.pin_id && hit < 0) hit = i;
      if (!ent_valid[i] && free_idx < 0) free_idx = i;
    end
    st = level_of(mask_copy, r.pin_id) ? pcnt_pkg::STAT_OK : pcnt_pkg::STAT_NOCHG;
    case (r.op)
      pcnt_pkg::OP_REG: begin
        if (hit >= 0) begin
          push_notice(pcnt_pkg::KIND_STATUS, pcnt_pkg::STAT_MISS, '0, 1'b0, 1'b1);
        end else if (free_idx < 0) begin
          push_notice(pcnt_pkg::KIND_STATUS, pcnt_pkg::STAT_FULL, '0, 1'b0, 1'b1);
        end else begin
          // A pin outside the mask is still stored, only the status differs.
          ent_valid[free_idx] = 1'b1;
          ent_pin[free_idx]   = r.pin_id;
          ent_level[free_idx] = level_of(r.pin_levels, r.pin_id);
          push_notice(pcnt_pkg::KIND_STATUS, st, '0, 1'b0, 1'b1);
        end
      end
      pcnt_pkg::OP_DEREG: begin
        if (hit >= 0) begin
          ent_valid[hit] = 1'b0;
          push_notice(pcnt_pkg::KIND_STATUS, st, '0, 1'b0, 1'b1);
        end else begin
          push_notice(pcnt_pkg::KIND_STATUS, pcnt_pkg::STAT_MISS, '0, 1'b0, 1'b1);
        end
      end
      pcnt_pkg::OP_SCAN: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (ent_valid[i]) begin
            now = level_of(r.pin_levels, ent_pin[i]);
            if (now != ent_level[i]) begin
              ent_level[i] = now;
              push_notice(pcnt_pkg::KIND_CHANGE, pcnt_pkg::STAT_OK, ent_pin[i], now, 1'b0);
              n++;
            end
          end
        end
        if (n == 0) push_notice(pcnt_pkg::KIND_QUIET, pcnt_pkg::STAT_OK, '0, 1'b0, 1'b1);
        else notice_q[notice_q.size()-1].last = 1'b1;
      end
      default: begin
        push_notice(pcnt_pkg::KIND_STATUS, pcnt_pkg::STAT_MISS, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void push_req(logic [pcnt_pkg::OP_W-1:0] op,
                                   logic [pcnt_pkg::PIN_W-1:0] pin,
                                   logic [pcnt_pkg::LVL_W-1:0] levels);
    req_t r;
    r.op         = op;
    r.pin_id     = pin;
    r.pin_levels = levels;
    req_q.push_back(r);
  endfunction

  // Mostly pins from a small pool so that the table fills, duplicates occur and
  // deregisters hit; levels mostly drift by a few bits so scans report sparse changes.
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    int unsigned idx;
    int unsigned flips;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.op = pcnt_pkg::OP_REG;
    else if (pick < 65) r.op = pcnt_pkg::OP_DEREG;
    else if (pick < 95) r.op = pcnt_pkg::OP_SCAN;
    else r.op = OP_UNDEF;
    if ($urandom_range(0, 3) != 0) begin
      r.pin_id = pcnt_pkg::PIN_W'(($urandom_range(0, 19) * 13) % 64);
    end else begin
      r.pin_id = pcnt_pkg::PIN_W'($urandom_range(0, 63));
    end
    if ($urandom_range(0, 9) < 7) begin
      flips = $urandom_range(0, 3);
      for (int k = 0; k < flips; k++) begin
        idx = $urandom_range(0, pcnt_pkg::LVL_W - 1);
        line_state[idx] = ~line_state[idx];
      end
    end else begin
      line_state = {$urandom, $urandom};
    end
    r.pin_levels = line_state;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Input side: record each accepted item and predict its results.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        apply_table_op('{op: in_if.op, pin_id: in_if.pin_id, pin_levels: in_if.pin_levels});
    end
  end

  // Output side: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    pcnt_pkg::res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (notice_q.size() == 0) begin
        $error("unexpected result: kind %0d status %0d pin %0d", out_if.kind, out_if.status,
               out_if.event_pin);
        mismatches++;
      end else begin
        want = notice_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_if.kind));
        check_field("status", 8'(want.status), 8'(out_if.status));
        check_field("event_pin", 8'(want.event_pin), 8'(out_if.event_pin));
        check_field("new_level", 8'(want.new_level), 8'(out_if.new_level));
        check_field("last", 8'(want.last), 8'(out_if.last));
      end
    end
  end

  always @(negedge clk_i) begin
    req_t nxt;
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.op         <= nxt.op;
        in_if.pin_id     <= nxt.pin_id;
        in_if.pin_levels <= nxt.pin_levels;
        send_gap = pick_gap(send_calm);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (take_stall > 0) begin
        out_if.ready <= 1'b0;
        take_stall--;
      end else begin
        out_if.ready <= 1'b1;
        take_stall = ($urandom_range(0, 3) == 0) ? pick_gap(take_calm) : 0;
        if ($urandom_range(0, 59) == 0) take_calm = !take_calm;
      end
    end
  end

  task automatic wait_drained();
    while (req_q.size() != 0 || in_if.valid || notice_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [pcnt_pkg::LVL_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    mask_copy = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [pcnt_pkg::LVL_W-1:0] mask);
    wait_drained();
    write_mask(mask);
    repeat (ITEMS_PER_PHASE) req_q.push_back(random_req());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = pcnt_pkg::OP_REG;
    in_if.pin_id = '0;
    in_if.pin_levels = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    line_state = {$urandom, $urandom};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset mask.
    push_req(pcnt_pkg::OP_SCAN, 6'd0, ALL_ZEROS);
    push_req(pcnt_pkg::OP_REG, 6'd0, ALL_ONES);
    push_req(pcnt_pkg::OP_REG, 6'd63, ALL_ZEROS);
    push_req(pcnt_pkg::OP_REG, 6'd0, ALL_ZEROS);
    push_req(pcnt_pkg::OP_DEREG, 6'd5, ALL_ZEROS);
    push_req(OP_UNDEF, 6'd63, ALL_ONES);
    push_req(pcnt_pkg::OP_SCAN, 6'd0, ALL_ONES);
    push_req(pcnt_pkg::OP_SCAN, 6'd63, ALL_ZEROS);
    push_req(pcnt_pkg::OP_SCAN, 6'd0, ALL_ZEROS);
    for (int p = 1; p <= 14; p++) push_req(pcnt_pkg::OP_REG, pcnt_pkg::PIN_W'(p), ALL_ZEROS);
    push_req(pcnt_pkg::OP_REG, 6'd20, ALL_ONES);
    // Every entry flips, so the scan gives the longest burst of results.
    push_req(pcnt_pkg::OP_SCAN, 6'd0, ALL_ONES);
    push_req(pcnt_pkg::OP_DEREG, 6'd63, ALL_ZEROS);
    push_req(pcnt_pkg::OP_REG, 6'd40, ALL_ONES);

    // No pin changeable: both a stored pin and a new one report it.
    wait_drained();
    write_mask(ALL_ZEROS);
    push_req(pcnt_pkg::OP_DEREG, 6'd0, ALL_ZEROS);
    push_req(pcnt_pkg::OP_REG, 6'd50, ALL_ONES);
    push_req(pcnt_pkg::OP_REG, 6'd50, ALL_ZEROS);
    push_req(pcnt_pkg::OP_SCAN, 6'd0, ALL_ZEROS);

    random_phase({$urandom, $urandom});
    random_phase(ALL_ONES);
    random_phase(pcnt_pkg::LVL_W'(1) << $urandom_range(0, pcnt_pkg::LVL_W - 1));
    random_phase({$urandom, $urandom});

    wait_drained();
    if (mismatches == 0 && notice_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
